/* rtl/vtm_pkg.sv */
// Types and constants shared by the climb-tone mapper modules.
// No dependencies.
package vtm_pkg;

    localparam int unsigned RateW = 11;

    typedef enum logic [1:0]
    {
        MODE_SILENT = 2'd0,
        MODE_SINK   = 2'd1,
        MODE_CLIMB  = 2'd2
    } mode_t;

    localparam logic [0:0] CFG_SINK_THR = 1'b0;
    localparam logic [0:0] CFG_RISE_THR = 1'b1;

    localparam logic signed [10:0] SINK_THR_RESET = -11'sd100;
    localparam logic [9:0]         RISE_THR_RESET = 10'd20;
    localparam logic [15:0]        TONE_RESET     = 16'd25000;

    // classified request passed from front to back
    typedef struct packed
    {
        mode_t                   mode;
        logic signed [RateW-1:0] rate;
    } job_t;

endpackage

/* rtl/vtm_if.sv */
// Valid/ready channel carrying a parameterised payload.
// Depends on nothing.
interface vtm_if #(parameter int unsigned W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/vtm_front.sv */
// Front end: clamps the sample, compares with the thresholds, emits a job.
// Depends on vtm_pkg.
module vtm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   alt_diff,
    input  logic signed [10:0]   sink_thr,
    input  logic [9:0]           rise_thr,
    output logic                 job_valid,
    input  logic                 job_ready,
    output vtm_pkg::job_t        job
);
    logic signed [10:0] rate;
    vtm_pkg::mode_t     mode;
    logic               full_reg, full_next;
    vtm_pkg::job_t      job_reg;

    always_comb
    begin
        if (alt_diff > 16'sd1000)
            rate = 11'sd1000;
        else if (alt_diff < -16'sd1000)
            rate = -11'sd1000;
        else
            rate = alt_diff[10:0];
        if (rate < sink_thr)
            mode = vtm_pkg::MODE_SINK;
        else if ($signed({rate[10], rate}) > $signed({2'b00, rise_thr}))
            mode = vtm_pkg::MODE_CLIMB;
        else
            mode = vtm_pkg::MODE_SILENT;
    end

    assign in_ready  = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job       = job_reg;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
            full_next = 1'b1;
        else if (job_ready)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            job_reg <= '{mode: mode, rate: rate};
    end
endmodule

/* rtl/vtm_queue.sv */
// Two-entry request queue between front and back ends.
// Depends on vtm_pkg.
module vtm_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  vtm_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output vtm_pkg::job_t rd_data
);
    vtm_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue count overflow");
    property p_empty_holds;
        @(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd0 && !wr) |=> cnt_reg == 2'd0;
    endproperty
    a_empty_holds: assert property (p_empty_holds) else $error("queue filled without write");
    property p_full_stall;
        @(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd2 && !rd) |=> cnt_reg == 2'd2;
    endproperty
    a_full_stall: assert property (p_full_stall) else $error("full queue lost entry");
endmodule

/* rtl/vtm_back.sv */
// Back end: polynomial sequencer, restoring divider and held periods.
// Depends on vtm_pkg.
module vtm_back #(parameter int unsigned TimerHz = 6000000)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  vtm_pkg::job_t job,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [1:0]    mode,
    output logic [15:0]   tone_period,
    output logic [6:0]    repeat_period
);
    typedef enum logic [6:0]
    {
        ST_IDLE = 7'b0000001,
        ST_SQ   = 7'b0000010,
        ST_CUBE = 7'b0000100,
        ST_POLY = 7'b0001000,
        ST_FDIV = 7'b0010000,
        ST_TDIV = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    localparam logic [25:0] Hz = 26'(TimerHz);
    // ceil(2^40 / 10000): exact quotient for numerators below 2^26
    localparam logic [26:0] FreqRecip = 27'd109951163;
    // ceil(2^49 / 1953125): exact quotient for numerators below 2^28
    localparam logic [28:0] RepRecip  = 29'd288230377;

    state_t state_reg, state_next;
    vtm_pkg::mode_t mode_reg;
    logic signed [10:0] a_reg;
    logic signed [21:0] sq_reg;      // a^2
    logic signed [31:0] cube_reg;    // a^3
    logic signed [26:0] fnum_reg;    // frequency numerator
    logic signed [39:0] rnum_reg;    // repeat numerator
    logic [4:0]  cnt_reg;
    logic [25:0] quo_reg, rem_reg, dvs_reg;
    logic [15:0] tone_reg;
    logic [6:0]  rep_reg;
    logic        fneg_reg;
    logic [26:0] trial;
    logic [25:0] rem_sh;
    logic [25:0] fabs;
    logic [52:0] fprod;
    logic [12:0] fq;
    logic [56:0] rprod;
    logic [7:0]  rq;

    assign job_ready = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_OUT;
    assign mode          = mode_reg;
    assign tone_period   = tone_reg;
    assign repeat_period = rep_reg;

    // one restoring step per cycle
    assign rem_sh = {rem_reg[24:0], quo_reg[25]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};
    assign fabs   = fnum_reg[26] ? 26'(-fnum_reg) : fnum_reg[25:0];

    // divide by 10000: 26 by 27 bit reciprocal product
    assign fprod = fabs * FreqRecip;
    assign fq    = fprod[52:40];

    // divide by 1e9 as a shift by 9 then a 28 by 29 bit reciprocal product
    assign rprod = rnum_reg[36:9] * RepRecip;
    assign rq    = rprod[56:49];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_CUBE;
            ST_CUBE: state_next = ST_POLY;
            ST_POLY: state_next = ST_FDIV;
            ST_FDIV: state_next = ST_TDIV;
            ST_TDIV: if (cnt_reg == 5'd0) state_next = ST_OUT;
            ST_OUT:  if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tone_reg  <= vtm_pkg::TONE_RESET;
            rep_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_TDIV && cnt_reg == 5'd0
                && mode_reg != vtm_pkg::MODE_SILENT)
            begin
                if (fneg_reg || fnum_reg == 27'sd0 || quo_reg[25:16] != 10'd0)
                    tone_reg <= 16'hFFFF;
                else
                    tone_reg <= quo_reg[15:0];
                if (mode_reg == vtm_pkg::MODE_CLIMB)
                begin
                    if (rnum_reg[39])
                        rep_reg <= 7'd0;
                    else if (rnum_reg[38:37] != 2'd0 || rq > 8'd127)
                        rep_reg <= 7'd127;
                    else
                        rep_reg <= rq[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                mode_reg <= job.mode;
                a_reg    <= job.rate;
            end
            ST_SQ:   sq_reg <= $signed({{11{a_reg[10]}}, a_reg})
                               * $signed({{11{a_reg[10]}}, a_reg});
            ST_CUBE: cube_reg <= $signed({{10{sq_reg[21]}}, sq_reg})
                                 * $signed({{21{a_reg[10]}}, a_reg});
            ST_POLY:
            begin
                if (mode_reg == vtm_pkg::MODE_SINK)
                    fnum_reg <= 27'(4 * sq_reg + 7222 * a_reg + 4500000);
                else
                    fnum_reg <= 27'(12 * sq_reg + 24400 * a_reg + 3250000);
                rnum_reg <= 40'(-40'sd106 * cube_reg + 40'sd253000 * sq_reg
                                - 40'sd207000000 * a_reg + 40'sd66000000000);
            end
            ST_FDIV:
            begin
                // f = trunc(num / 10000) from the magnitude; a negative numerator gives zero and sets fneg_reg
                fneg_reg <= fnum_reg[26];
                fnum_reg <= fnum_reg[26] ? 27'sd0 : 27'(fq);
                dvs_reg  <= 26'(fq);
                quo_reg  <= Hz;
                rem_reg  <= 26'd0;
                cnt_reg  <= 5'd26;
            end
            ST_TDIV:
            begin
                if (cnt_reg != 5'd0)
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (!trial[26])
                    begin
                        rem_reg <= trial[25:0];
                        quo_reg <= {quo_reg[24:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[24:0], 1'b0};
                    end
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    property p_out_holds;
        @(posedge clk) disable iff (!rst_n)
            (res_valid && !res_ready) |=> res_valid && $stable(tone_reg);
    endproperty
    a_out_holds: assert property (p_out_holds) else $error("result changed under stall");
    property p_silent_keeps;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_TDIV && mode_reg == vtm_pkg::MODE_SILENT)
            |=> $stable(tone_reg) && $stable(rep_reg);
    endproperty
    a_silent_keeps: assert property (p_silent_keeps) else $error("silent mode wrote periods");
    property p_one_job;
        @(posedge clk) disable iff (!rst_n) job_ready |-> !res_valid;
    endproperty
    a_one_job: assert property (p_one_job) else $error("overlapping jobs");
endmodule

/* rtl/vario_tone_mapper_top.sv */
// Climb-tone mapper: a climb-rate request in, one mode/period result out.
// Items pass in_ch (16-bit alt_diff) and leave on out_ch as
// {mode, tone_period, repeat_period}. Config writes: cfg_we, cfg_idx, cfg_data.
// Front stage clamps and classifies into a registered job that feeds a two-entry queue; the
// back end computes a^2, a^3, the polynomials, the frequency, then a 26-step
// restoring division of TIMER_HZ by the frequency.
// The back end takes a new item only after the last result is accepted: it walks
// six fixed states and the 26-step divider for each item.
// Reset returns thresholds to -100 and 20, tone period to 25000, repeat to 0.
// While out_ch is stalled the result holds; the queue fills, then in_ch
// drops ready.
// Depends on vtm_pkg, vtm_if, vtm_front, vtm_queue, vtm_back.
module vario_tone_mapper_top #(parameter int unsigned TIMER_HZ = 6000000)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [10:0] cfg_data,
    vtm_if.sink         in_ch,
    vtm_if.source       out_ch
);
    logic signed [10:0] sink_thr_reg;
    logic [9:0]         rise_thr_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    vtm_pkg::job_t f_job, q_job;
    logic [1:0]  mode;
    logic [15:0] tone_period;
    logic [6:0]  repeat_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_thr_reg <= vtm_pkg::SINK_THR_RESET;
            rise_thr_reg <= vtm_pkg::RISE_THR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == vtm_pkg::CFG_SINK_THR)
                sink_thr_reg <= cfg_data;
            else
                rise_thr_reg <= cfg_data[9:0];
        end
    end

    vtm_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .alt_diff(in_ch.data[15:0]),
        .sink_thr(sink_thr_reg), .rise_thr(rise_thr_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    vtm_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    vtm_back #(.TimerHz(TIMER_HZ)) u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready),
        .mode(mode), .tone_period(tone_period), .repeat_period(repeat_period)
    );

    assign out_ch.data = {mode, tone_period, repeat_period};
endmodule

/* sim/vario_tone_mapper_top_test.sv */
// Self-checking bench for the climb-tone mapper: drives climb-rate requests and
// threshold writes, and predicts mode, tone period and repeat period for each request.
// Depends on vtm_pkg, vtm_if and vario_tone_mapper_top.
module vario_tone_mapper_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int     SETTLE      = 40;

    typedef struct
    {
        vtm_pkg::mode_t mode;
        logic [15:0]    tone;
        logic [6:0]     rpt;
    } tone_result_t;

    class tone_board;
        tone_result_t  pending[$];
        longint        sink_thr;
        longint        rise_thr;
        logic   [15:0] tone_hold;
        logic   [6:0]  rpt_hold;
        int            errors;
        int            checked;
        int            mode_seen[3];

        function new();
            sink_thr  = -100;
            rise_thr  = 20;
            tone_hold = 16'd25000;
            rpt_hold  = 7'd0;
            errors    = 0;
            checked   = 0;
            mode_seen = '{0, 0, 0};
        endfunction

        function logic [15:0] period_of(longint f);
            longint p;
            if (f <= 0)
                return 16'hFFFF;
            p = 64'sd6000000 / f;
            if (p > 65535)
                p = 65535;
            return p[15:0];
        endfunction

        // work out the result of one accepted request and queue it
        function void note_request(logic [15:0] raw);
            longint       a;
            longint       r;
            tone_result_t res;
            a = longint'($signed(raw));
            if (a > 1000)
                a = 1000;
            if (a < -1000)
                a = -1000;
            if (a < sink_thr)
            begin
                res.mode  = vtm_pkg::MODE_SINK;
                tone_hold = period_of((4 * a * a + 7222 * a + 4500000) / 10000);
            end
            else if (a > rise_thr)
            begin
                res.mode  = vtm_pkg::MODE_CLIMB;
                tone_hold = period_of((12 * a * a + 24400 * a + 3250000) / 10000);
                r = (-106 * a * a * a + 253000 * a * a - 207000000 * a
                     + 64'sd66000000000) / 64'sd1000000000;
                if (r < 0)
                    r = 0;
                if (r > 127)
                    r = 127;
                rpt_hold = r[6:0];
            end
            else
            begin
                res.mode = vtm_pkg::MODE_SILENT;
            end
            res.tone = tone_hold;
            res.rpt  = rpt_hold;
            pending.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch on result %0d: %s got %0d, expected %0d",
                     checked, what, got, want);
        endtask

        task check_result(logic [24:0] data);
            tone_result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", 32'(data), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (data[24:23] != want.mode)
                report("mode", 32'(data[24:23]), 32'(want.mode));
            if (data[22:7] != want.tone)
                report("tone_period", 32'(data[22:7]), 32'(want.tone));
            if (data[6:0] != want.rpt)
                report("repeat_period", 32'(data[6:0]), 32'(want.rpt));
            if (want.mode <= vtm_pkg::MODE_CLIMB)
                mode_seen[want.mode]++;
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [10:0] cfg_data;
    longint      cycles;
    int          stall_pct;
    int          send_idle_pct;
    int          hold_off;
    tone_board   board;

    vtm_if #(.W(16)) in_ch();
    vtm_if #(.W(25)) out_ch();

    vario_tone_mapper_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        board         = new();
        cycles        = 0;
        stall_pct     = 0;
        send_idle_pct = 0;
        hold_off      = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = vtm_pkg::CFG_SINK_THR;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: long hold-off first, otherwise stall at the phase rate
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off     <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_request(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.data);
    end

    task drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_thresholds(logic signed [10:0] sink, logic [9:0] rise);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= vtm_pkg::CFG_SINK_THR;
        cfg_data <= sink;
        @(posedge clk);
        cfg_idx  <= vtm_pkg::CFG_RISE_THR;
        cfg_data <= {1'b0, rise};
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.sink_thr = longint'(sink);
        board.rise_thr = longint'(rise);
    endtask

    // offer one request and hold it until taken, then maybe idle
    task send_request(logic [15:0] value);
        in_ch.valid <= 1'b1;
        in_ch.data  <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task finish_burst();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function logic [15:0] pick_rate();
        int     sel;
        longint v;
        sel = $urandom_range(99);
        if (sel < 55)
            v = $urandom_range(2200) - 1100;
        else if (sel < 75)
            v = board.sink_thr + $urandom_range(6) - 3;
        else if (sel < 90)
            v = board.rise_thr + $urandom_range(6) - 3;
        else
            return 16'($urandom());
        return v[15:0];
    endfunction

    logic [15:0] edge_rates[$] = '{16'h8000, 16'h7FFF, 16'hFC18, 16'hFC17, 16'h03E8,
        16'h03E9, 16'h0000, 16'hFFFF, 16'h0001, 16'hFF9C, 16'hFF9B, 16'h0014, 16'h0015,
        16'h5555, 16'hAAAA, 16'h01F4, 16'hFE0C};

    logic signed [10:0] sink_set[8] = '{-11'sd100, -11'sd1000, 11'sd0, -11'sd1,
        11'sd500, 11'sh400, 11'sd1023, -11'sd300};
    logic [9:0]         rise_set[8] = '{10'd20, 10'd0, 10'd1000, 10'd1023,
        10'd0, 10'd1, 10'd5, 10'd700};

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and threshold edges under reset settings
        foreach (edge_rates[i])
            send_request(edge_rates[i]);
        finish_burst();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_thresholds(sink_set[ph], rise_set[ph]);
            case (ph % 4)
                0: begin stall_pct = 0;  send_idle_pct = 0;  end
                1: begin stall_pct = 0;  send_idle_pct = 65; end
                2: begin stall_pct = 65; send_idle_pct = 0;  end
                default: begin stall_pct = 11; send_idle_pct = 11; end
            endcase
            if (ph == 2)
                hold_off = 400;
            // sink wins when the thresholds overlap
            if (ph == 4)
            begin
                send_request(16'd100);
                send_request(16'd499);
                send_request(16'd500);
            end
            for (int n = 0; n < 235; n++)
            begin
                send_request(pick_rate());
                if (ph == 5 && n == 100)
                begin
                    finish_burst();
                    drain();
                end
            end
            finish_burst();
        end

        drain();
        $display("checked %0d results: %0d silent, %0d sink, %0d climb",
                 board.checked, board.mode_seen[0], board.mode_seen[1],
                 board.mode_seen[2]);
        $display("over 8 threshold settings, with input gaps and output stalls");
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
